// ----- src/beep_pattern_queue_sequencer_macros.svh -----
// assertion macros for the beep pattern queue sequencer
// used by src/beep_pattern_queue_sequencer.sv; needs nothing else
`ifndef BEEP_PATTERN_QUEUE_SEQUENCER_MACROS_SVH
`define BEEP_PATTERN_QUEUE_SEQUENCER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define BPQS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpqs assertion failed");
// next-cycle implication
`define BPQS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpqs assertion failed");
`else
`define BPQS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define BPQS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- src/bpqs_pkg.sv -----
// package for the beep pattern queue sequencer: queue sizing, field widths,
// phase encoding and the stored pattern entry; depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package bpqs_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W       = SLOT_W + 1;
   localparam int PENDING_W   = $clog2(QUEUE_DEPTH * 255 + 1);

   localparam int TIME_W      = 32;
   localparam int DUR_W       = 16;
   localparam int REPS_W      = 8;
   localparam int LEVEL_W     = 8;
   localparam int BEEPS_W     = 11;
   localparam int BEEPS_MAX   = 2047;

   localparam logic [LEVEL_W-1:0] RESET_ON_LEVEL = 8'd128;

   // request kinds
   localparam logic REQ_TIME   = 1'b0;
   localparam logic REQ_APPEND = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_ARMED    = 2'd1,
      PH_SOUNDING = 2'd2
   } phase_type;

   typedef struct packed {
      logic [DUR_W-1:0]  on_t;
      logic [DUR_W-1:0]  off_t;
      logic [REPS_W-1:0] reps;
   } entry_type;

endpackage
`default_nettype wire

// ----- src/beep_pattern_queue_sequencer.sv -----
// result: registered; a result beat appears in the cycle after its request beat is taken
// throughput: one request beat per cycle; the single output register is
//   refilled in the cycle it drains, so only a stalled rsp side holds req off
// reset: synchronous, active high; queue empty, phase idle, level 0, time 0,
//   on-level register 128; pattern entries hold no reset value
// file depends on bpqs_pkg and beep_pattern_queue_sequencer_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "beep_pattern_queue_sequencer_macros.svh"
module beep_pattern_queue_sequencer
   import bpqs_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   // request channel
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire                 req_type,
   input  wire  [TIME_W-1:0]   req_now_time,
   input  wire  [DUR_W-1:0]    req_on_time,
   input  wire  [DUR_W-1:0]    req_off_time,
   input  wire  [REPS_W-1:0]   req_repeat_count,
   // result channel
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output logic [LEVEL_W-1:0]  rsp_drive_level,
   output logic [BEEPS_W-1:0]  rsp_beeps_left,
   output logic                rsp_busy_res,
   output logic                rsp_add_dropped,
   // configuration write channel
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire  [LEVEL_W-1:0]  csr_drive_on_level
);

   // ---------------------------------------------------------------
   // architectural state
   // ---------------------------------------------------------------
   entry_type              store_ff [QUEUE_DEPTH];   // no reset, written before read
   logic [SLOT_W-1:0]      head_ff,    head_in;
   logic [COUNT_W-1:0]     held_ff,    held_in;
   logic [PENDING_W-1:0]   pending_ff, pending_in;
   phase_type              phase_ff,   phase_in;
   logic [TIME_W-1:0]      last_ff,    last_in;
   logic [DUR_W-1:0]       interval_ff, interval_in;
   logic [LEVEL_W-1:0]     level_ff,   level_in;
   logic [LEVEL_W-1:0]     on_level_ff;

   // output register
   logic                   rsp_valid_ff;
   logic [LEVEL_W-1:0]     rsp_level_ff;
   logic [BEEPS_W-1:0]     rsp_beeps_ff;
   logic                   rsp_busy_ff;
   logic                   rsp_drop_ff;

   logic                   req_beat;
   logic                   is_append;
   logic                   is_time;
   logic                   elapsed_hit;
   logic                   step_en;
   logic [TIME_W-1:0]      elapsed;

   entry_type              head_entry;
   logic [REPS_W-1:0]      head_reps_dec;
   logic                   head_pop;
   logic [SLOT_W-1:0]      head_next;
   logic [SUM_W-1:0]       tail_sum;
   logic [SLOT_W-1:0]      tail_slot;

   logic                   append_ok;
   logic                   append_drop;
   logic                   store_head_wr;
   logic [PENDING_W-1:0]   pending_dec;
   logic [COUNT_W-1:0]     held_dec;

   logic [PENDING_W+BEEPS_W-1:0] pending_wide;
   logic [BEEPS_W-1:0]     beeps_sat;

   // ---------------------------------------------------------------
   // handshakes: output register frees up in the cycle it drains
   // ---------------------------------------------------------------
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_beat  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign is_append = req_beat && (req_type == REQ_APPEND);
   assign is_time   = req_beat && (req_type == REQ_TIME);

   // wrapping elapsed time against the current interval
   assign elapsed     = req_now_time - last_ff;
   assign elapsed_hit = elapsed > {{(TIME_W-DUR_W){1'b0}}, interval_ff};
   assign step_en     = is_time && elapsed_hit;

   // ---------------------------------------------------------------
   // queue pointers
   // ---------------------------------------------------------------
   assign head_entry    = store_ff[head_ff];
   assign head_reps_dec = (head_entry.reps != '0) ? head_entry.reps - 1'b1 : head_entry.reps;
   assign head_pop      = (head_reps_dec == '0);
   assign head_next     = (head_ff == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // tail = (head + held) mod depth, held < depth whenever it is used
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(held_ff);
   assign tail_slot = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                      ? SLOT_W'(tail_sum - SUM_W'(QUEUE_DEPTH))
                      : tail_sum[SLOT_W-1:0];

   // zero-repeat appends are ignored, not flagged
   assign append_drop = is_append && (req_repeat_count != '0)
                        && (held_ff >= COUNT_W'(QUEUE_DEPTH));
   assign append_ok   = is_append && (req_repeat_count != '0)
                        && (held_ff < COUNT_W'(QUEUE_DEPTH));

   assign pending_dec = (pending_ff != '0) ? pending_ff - 1'b1 : pending_ff;
   assign held_dec    = head_pop ? held_ff - 1'b1 : held_ff;

   // ---------------------------------------------------------------
   // phase machine: next state
   // ---------------------------------------------------------------
   always_comb begin
      phase_in = phase_ff;
      if (step_en) begin
         unique case (phase_ff)
            PH_ARMED: begin
               phase_in = (held_ff == '0) ? PH_IDLE : PH_SOUNDING;
            end
            PH_SOUNDING: begin
               // empty queue or nothing left after this beep ends the run
               if (held_ff == '0 || pending_dec == '0 || held_dec == '0) begin
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_ARMED;
               end
            end
            default: begin
               // idle, and the unused code behaves as idle
               phase_in = (pending_ff != '0) ? PH_ARMED : PH_IDLE;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // phase machine: datapath outputs
   // ---------------------------------------------------------------
   always_comb begin
      head_in       = head_ff;
      held_in       = held_ff;
      pending_in    = pending_ff;
      interval_in   = interval_ff;
      level_in      = level_ff;
      last_in       = last_ff;
      store_head_wr = 1'b0;

      if (append_ok) begin
         held_in    = held_ff + 1'b1;
         pending_in = pending_ff + PENDING_W'(req_repeat_count);
      end

      if (step_en) begin
         last_in = req_now_time;
         unique case (phase_ff)
            PH_ARMED: begin
               if (held_ff == '0) begin
                  level_in    = '0;
                  interval_in = '0;
               end else begin
                  level_in    = on_level_ff;
                  interval_in = head_entry.on_t;
               end
            end
            PH_SOUNDING: begin
               level_in = '0;
               if (held_ff == '0) begin
                  interval_in = '0;
               end else begin
                  // one beep off the head entry and the running total
                  store_head_wr = 1'b1;
                  pending_in    = pending_dec;
                  held_in       = held_dec;
                  if (head_pop) begin
                     head_in = head_next;
                  end
                  if (pending_dec == '0 || held_dec == '0) begin
                     interval_in = '0;
                  end else begin
                     interval_in = head_entry.off_t;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // state registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         held_ff     <= '0;
         pending_ff  <= '0;
         phase_ff    <= PH_IDLE;
         last_ff     <= '0;
         interval_ff <= '0;
         level_ff    <= '0;
         on_level_ff <= RESET_ON_LEVEL;
      end else begin
         head_ff     <= head_in;
         held_ff     <= held_in;
         pending_ff  <= pending_in;
         phase_ff    <= phase_in;
         last_ff     <= last_in;
         interval_ff <= interval_in;
         level_ff    <= level_in;
         if (csr_valid && csr_ready) begin
            on_level_ff <= csr_drive_on_level;
         end
      end
   end

   // pattern entries: append writes the tail, a finished beep rewrites the
   // head's repeat count; one beat never does both
   always_ff @(posedge clock) begin
      if (append_ok) begin
         store_ff[tail_slot] <= '{on_t: req_on_time, off_t: req_off_time,
                                  reps: req_repeat_count};
      end else if (store_head_wr) begin
         store_ff[head_ff].reps <= head_reps_dec;
      end
   end

   // ---------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------
   assign pending_wide = (PENDING_W+BEEPS_W)'(pending_in);
   assign beeps_sat    = (pending_wide > (PENDING_W+BEEPS_W)'(BEEPS_MAX))
                         ? BEEPS_W'(BEEPS_MAX) : pending_wide[BEEPS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_beat) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         rsp_level_ff <= level_in;
         rsp_beeps_ff <= beeps_sat;
         rsp_busy_ff  <= (pending_in != '0);
         rsp_drop_ff  <= append_drop;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_level = rsp_level_ff;
   assign rsp_beeps_left  = rsp_beeps_ff;
   assign rsp_busy_res    = rsp_busy_ff;
   assign rsp_add_dropped = rsp_drop_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   `BPQS_ASSERT_IMPL(a_sound_has_work, clock, reset, phase_ff == PH_SOUNDING, held_ff != '0 && pending_ff != '0)
   `BPQS_ASSERT_IMPL(a_empty_no_pending, clock, reset, held_ff == '0, pending_ff == '0)
   `BPQS_ASSERT_IMPL(a_level_only_sounding, clock, reset, level_ff != '0, phase_ff == PH_SOUNDING)
   `BPQS_ASSERT_NEXT(a_beat_gives_result, clock, reset, req_beat, rsp_valid_ff)

endmodule
`default_nettype wire
